// File: src/sta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_pkg
// Shared sizes, codes and helpers for the slot table with ID allocator.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int ID_W       = 16;
  localparam int TEXT_CHARS = 8;
  localparam int TEXT_W     = 64;
  localparam int MODE_W     = 3;
  localparam int STAT_W     = 2;

  localparam logic [TEXT_W-1:0] TEXT_MASK = {TEXT_W{1'b1}} >> (TEXT_W - 8 * TEXT_CHARS);
  localparam logic [ID_W-1:0]   ID_MAX    = {ID_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET_SUR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_GIV = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd3;

  // where a result text comes from
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_IN   = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } sta_cmd_t;

  typedef struct packed {
    logic out_free;
  } sta_stat_t;

  // lowest set bit wins
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: src/sta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ram
// Generic single-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/sta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ctrl
// Sequencer: capture a beat, execute it against the table, load the result.
// ----------------------------------------------------------------------------
module sta_ctrl import sta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sta_stat_t stat,
  output sta_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall    = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.load    = (state_r == S_RESP) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register can take the result
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/sta_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_dpath
// Slot valid marks, ID registers, ID counter, text RAMs and result register.
// ----------------------------------------------------------------------------
module sta_dpath import sta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sta_cmd_t          cmd,
  output sta_stat_t         stat,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ID_W-1:0]   in_key_id,
  input  logic [TEXT_W-1:0] in_surname_in,
  input  logic [TEXT_W-1:0] in_given_name_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [ID_W-1:0]   out_record_id,
  output logic [TEXT_W-1:0] out_surname_out,
  output logic [TEXT_W-1:0] out_given_name_out
);

  // table state
  logic [SLOTS-1:0] valid_r;
  logic [ID_W-1:0]  ids_r [SLOTS];
  logic [ID_W-1:0]  counter_r;

  // captured beat and search result
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   key_r;
  logic [TEXT_W-1:0] sur_r;
  logic [TEXT_W-1:0] giv_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_slot_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_slot_r;

  // pending result
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [1:0]        res_sur_src_r, res_sur_src_nxt;
  logic [1:0]        res_giv_src_r, res_giv_src_nxt;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TEXT_W-1:0] out_sur_r;
  logic [TEXT_W-1:0] out_giv_r;

  logic [SLOTS-1:0]  match_vec;
  logic [SLOTS-1:0]  free_vec;

  logic              valid_set, valid_clr;
  logic [SLOT_W-1:0] valid_idx;
  logic [ID_W-1:0]   counter_nxt;
  logic              sur_we, sur_re, giv_we, giv_re;
  logic [SLOT_W-1:0] ram_addr;
  logic [TEXT_W-1:0] sur_rdata, giv_rdata;
  logic [TEXT_W-1:0] sur_sel, giv_sel;

  // parallel compare across all slots
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid_r[i] && (ids_r[i] == in_key_id);
      free_vec[i]  = !valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r       <= in_mode;
      key_r        <= in_key_id;
      sur_r        <= in_surname_in & TEXT_MASK;
      giv_r        <= in_given_name_in & TEXT_MASK;
      hit_r        <= |match_vec;
      hit_slot_r   <= first_set(match_vec);
      free_found_r <= |free_vec;
      free_slot_r  <= first_set(free_vec);
    end
  end

  always_comb begin
    valid_set       = 1'b0;
    valid_clr       = 1'b0;
    valid_idx       = hit_slot_r;
    counter_nxt     = counter_r;
    sur_we          = 1'b0;
    sur_re          = 1'b0;
    giv_we          = 1'b0;
    giv_re          = 1'b0;
    ram_addr        = hit_slot_r;
    res_status_nxt  = STAT_NOT_FOUND;
    res_slot_nxt    = '0;
    res_id_nxt      = '0;
    res_sur_src_nxt = SRC_ZERO;
    res_giv_src_nxt = SRC_ZERO;
    case (mode_r)
      MODE_INSERT: begin
        ram_addr  = free_slot_r;
        valid_idx = free_slot_r;
        if (!free_found_r) begin
          res_status_nxt = STAT_FULL;
        end else if (counter_r == ID_MAX) begin
          res_status_nxt = STAT_EXHAUSTED;
        end else begin
          counter_nxt     = counter_r + 1'b1;
          valid_set       = 1'b1;
          sur_we          = 1'b1;
          giv_we          = 1'b1;
          res_status_nxt  = STAT_OK;
          res_slot_nxt    = free_slot_r;
          res_id_nxt      = counter_r + 1'b1;
          res_sur_src_nxt = SRC_IN;
          res_giv_src_nxt = SRC_IN;
        end
      end
      MODE_DELETE: begin
        if (hit_r) begin
          // texts read back as zero; stale RAM data is never seen again
          valid_clr      = 1'b1;
          res_status_nxt = STAT_OK;
          res_slot_nxt   = hit_slot_r;
          res_id_nxt     = key_r;
        end
      end
      MODE_LOOKUP: begin
        if (hit_r) begin
          sur_re          = 1'b1;
          giv_re          = 1'b1;
          res_status_nxt  = STAT_OK;
          res_slot_nxt    = hit_slot_r;
          res_id_nxt      = key_r;
          res_sur_src_nxt = SRC_RAM;
          res_giv_src_nxt = SRC_RAM;
        end
      end
      MODE_SET_SUR: begin
        if (hit_r) begin
          sur_we          = 1'b1;
          giv_re          = 1'b1;
          res_status_nxt  = STAT_OK;
          res_slot_nxt    = hit_slot_r;
          res_id_nxt      = key_r;
          res_sur_src_nxt = SRC_IN;
          res_giv_src_nxt = SRC_RAM;
        end
      end
      MODE_SET_GIV: begin
        if (hit_r) begin
          giv_we          = 1'b1;
          sur_re          = 1'b1;
          res_status_nxt  = STAT_OK;
          res_slot_nxt    = hit_slot_r;
          res_id_nxt      = key_r;
          res_sur_src_nxt = SRC_RAM;
          res_giv_src_nxt = SRC_IN;
        end
      end
      default: begin
        res_status_nxt = STAT_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      counter_r <= '0;
    end else if (cmd.exec) begin
      counter_r <= counter_nxt;
      if (valid_set) valid_r[valid_idx] <= 1'b1;
      if (valid_clr) valid_r[valid_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && valid_set) begin
      ids_r[valid_idx] <= counter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r  <= res_status_nxt;
      res_slot_r    <= res_slot_nxt;
      res_id_r      <= res_id_nxt;
      res_sur_src_r <= res_sur_src_nxt;
      res_giv_src_r <= res_giv_src_nxt;
    end
  end

  sta_ram #(
    .WIDTH (TEXT_W),
    .DEPTH (SLOTS)
  ) u_sur_ram (
    .clk   (clk),
    .we    (cmd.exec && sur_we),
    .re    (cmd.exec && sur_re),
    .addr  (ram_addr),
    .wdata (sur_r),
    .rdata (sur_rdata)
  );

  sta_ram #(
    .WIDTH (TEXT_W),
    .DEPTH (SLOTS)
  ) u_giv_ram (
    .clk   (clk),
    .we    (cmd.exec && giv_we),
    .re    (cmd.exec && giv_re),
    .addr  (ram_addr),
    .wdata (giv_r),
    .rdata (giv_rdata)
  );

  always_comb begin
    case (res_sur_src_r)
      SRC_IN:  sur_sel = sur_r;
      SRC_RAM: sur_sel = sur_rdata;
      default: sur_sel = '0;
    endcase
    case (res_giv_src_r)
      SRC_IN:  giv_sel = giv_r;
      SRC_RAM: giv_sel = giv_rdata;
      default: giv_sel = '0;
    endcase
  end

  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_id_r     <= res_id_r;
      out_sur_r    <= sur_sel;
      out_giv_r    <= giv_sel;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_r;
  assign out_record_id      = out_id_r;
  assign out_surname_out    = out_sur_r;
  assign out_given_name_out = out_giv_r;

endmodule

// File: src/slot_table_id_alloc_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_id_alloc_top
// Slot table with ID allocator: insert, delete, lookup and text updates.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in_      | in_valid / in_stall | mode, key_id, surname_in, given_name_in
//  out_     | out_valid/out_stall | status, slot_index, record_id, texts
//
//  Each beat steps through capture with the parallel ID compare and lowest
//  free slot pick, execute against the table and text RAMs (one RAM port),
//  then load the output register. in_stall is high during execute and load.
//  A stalled output register holds the load step until it drains.
//  Synchronous reset clears every valid mark and the ID counter.
// ----------------------------------------------------------------------------
module slot_table_id_alloc_top import sta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ID_W-1:0]   in_key_id,
  input  logic [TEXT_W-1:0] in_surname_in,
  input  logic [TEXT_W-1:0] in_given_name_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [ID_W-1:0]   out_record_id,
  output logic [TEXT_W-1:0] out_surname_out,
  output logic [TEXT_W-1:0] out_given_name_out
);

  sta_cmd_t  cmd;
  sta_stat_t stat;

  sta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sta_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_mode),
    .in_key_id          (in_key_id),
    .in_surname_in      (in_surname_in),
    .in_given_name_in   (in_given_name_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_record_id      (out_record_id),
    .out_surname_out    (out_surname_out),
    .out_given_name_out (out_given_name_out)
  );

endmodule
